>>> hw/rtl/clcs_pkg.sv
// ----------------------------------------------------------------------------
// clcs_pkg - shared types for the cyclic longest common run unit
// Sequencer state encoding.
// ----------------------------------------------------------------------------
package clcs_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_CELL,
        S_DRAIN,
        S_OUT
    } t_state;

endpackage

>>> hw/rtl/cyclic_longest_common_substring_unit.sv
// ----------------------------------------------------------------------------
// cyclic_longest_common_substring_unit - cyclic longest common run finder
// Loads a field word and a pattern word of 2-bit direction symbols, one
// symbol per transfer (start high while busy is low). A pattern symbol with
// i_last set runs a suffix-match dynamic program over both words doubled,
// walking one cell per cycle (a setup state opens each row) through a shared
// compare/increment unit and a single row memory of 2*MAX_WORD run lengths.
// A comparison with field length F walks 2F rows, each a setup state and
// then one cell state per doubled pattern symbol, then a drain state and
// the result state; an empty field goes straight to the result state.
// The result appears for exactly one cycle with o_valid high, in the last
// busy cycle; the receiver cannot stall and must take it then.
// Synchronous reset clears both word lengths and the sticky overflow flag;
// the symbol and row memories need no clearing. After each result the
// pattern length returns to zero; the field word is kept until reset.
// Symbols beyond MAX_WORD are dropped and flagged on o_overflow.
// ----------------------------------------------------------------------------
module cyclic_longest_common_substring_unit #(
    parameter int MAX_WORD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_mode,
    input  logic [1:0] i_symbol,
    input  logic       i_last,
    input  logic [1:0] i_rotation_tag,
    output logic       o_valid,
    output logic [7:0] o_match_length,
    output logic [5:0] o_field_start,
    output logic [5:0] o_pattern_start,
    output logic [1:0] o_tag_out,
    output logic       o_overflow
);
    import clcs_pkg::*;

    localparam int AW = $clog2(MAX_WORD);
    localparam int CW = $clog2(MAX_WORD + 1);
    localparam int DW = AW + 1;
    localparam int LW = $clog2(2 * MAX_WORD + 1);
    localparam int ROWS = 2 * MAX_WORD;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_fcount, r_pcount;
    logic            r_ovf;
    logic [1:0]      r_tag;

    logic [1:0]      field_mem [MAX_WORD];
    logic [1:0]      pat_mem   [MAX_WORD];
    logic [LW-1:0]   row_mem   [ROWS];

    logic [LW-1:0]   r_rows_left;
    logic [AW-1:0]   r_fi, r_frow, r_pj, r_bpj;
    logic [DW-1:0]   r_jj, r_bj;
    logic            r_first_row, r_bfr, r_bfirst, r_bv;
    logic [1:0]      r_fsym, r_psym;
    logic [LW-1:0]   r_rd, r_diag;
    logic [LW-1:0]   r_best;
    logic [AW-1:0]   r_fstart, r_pstart;

    logic            accept, compare, f_full, p_full, eq;
    logic [AW-1:0]   fi_top, pj_top;
    logic [DW-1:0]   jj_top;
    logic [LW-1:0]   rd_eff, diag, len;
    logic [LW+7:0]   best_ext;
    logic [AW+5:0]   fstart_ext, pstart_ext;

    assign accept  = start && !busy;
    assign compare = accept && i_mode && i_last;
    assign f_full  = (r_fcount == CW'(MAX_WORD));
    assign p_full  = (r_pcount == CW'(MAX_WORD));
    assign fi_top  = AW'(r_fcount - CW'(1));
    assign pj_top  = AW'(r_pcount - CW'(1));
    assign jj_top  = {pj_top, 1'b1};

    assign rd_eff  = r_bfr ? '0 : r_rd;
    assign diag    = r_bfirst ? '0 : r_diag;
    assign eq      = (r_fsym == r_psym);
    assign len     = eq ? diag + LW'(1) : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (compare) begin
                    n_state = (r_fcount == '0) ? S_OUT : S_ROW;
                end
            end
            S_ROW: n_state = S_CELL;
            S_CELL: begin
                if (r_jj == '0) begin
                    n_state = (r_rows_left == LW'(1)) ? S_DRAIN : S_ROW;
                end
            end
            S_DRAIN: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fcount <= '0;
            r_pcount <= '0;
            r_ovf    <= 1'b0;
            r_bv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bv    <= (r_state == S_CELL);
            if (accept) begin
                if (!i_mode) begin
                    if (!f_full) r_fcount <= r_fcount + CW'(1);
                    else         r_ovf    <= 1'b1;
                end else begin
                    if (!p_full) r_pcount <= r_pcount + CW'(1);
                    else         r_ovf    <= 1'b1;
                end
            end
            if (r_state == S_OUT) begin
                r_pcount <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_mode && !f_full) begin
            field_mem[r_fcount[AW-1:0]] <= i_symbol;
        end
        if (r_state == S_ROW) begin
            r_fsym <= field_mem[r_fi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_mode && !p_full) begin
            pat_mem[r_pcount[AW-1:0]] <= i_symbol;
        end
        if (r_state == S_CELL) begin
            r_psym <= pat_mem[r_pj];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_bv) begin
            row_mem[r_bj] <= len;
        end
        if (r_state == S_CELL) begin
            r_rd <= row_mem[r_jj];
        end
    end

    always_ff @(posedge i_clk) begin
        if (compare) begin
            r_tag       <= i_rotation_tag;
            r_best      <= '0;
            r_fstart    <= '0;
            r_pstart    <= '0;
            r_first_row <= 1'b1;
            r_rows_left <= LW'({r_fcount, 1'b0});
            r_fi        <= fi_top;
        end
        if (r_state == S_ROW) begin
            r_frow <= r_fi;
            r_jj   <= jj_top;
            r_pj   <= pj_top;
        end
        if (r_state == S_CELL) begin
            r_bj     <= r_jj;
            r_bpj    <= r_pj;
            r_bfirst <= (r_jj == jj_top);
            r_bfr    <= r_first_row;
            r_jj     <= r_jj - DW'(1);
            r_pj     <= (r_pj == '0) ? pj_top : r_pj - AW'(1);
            if (r_jj == '0) begin
                r_rows_left <= r_rows_left - LW'(1);
                r_fi        <= (r_fi == '0) ? fi_top : r_fi - AW'(1);
                r_first_row <= 1'b0;
            end
        end
        if (r_bv) begin
            r_diag <= rd_eff;
            if (eq && (len > r_best)) begin
                r_best   <= len;
                r_fstart <= r_frow;
                r_pstart <= r_bpj;
            end
        end
    end

    assign best_ext   = {8'd0, r_best};
    assign fstart_ext = {6'd0, r_fstart};
    assign pstart_ext = {6'd0, r_pstart};

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_match_length  = (|best_ext[LW+7:8]) ? 8'hFF : best_ext[7:0];
    assign o_field_start   = fstart_ext[5:0];
    assign o_pattern_start = pstart_ext[5:0];
    assign o_tag_out       = r_tag;
    assign o_overflow      = r_ovf;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_compare_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        compare |=> busy)
        else $error("comparison transfer did not raise busy");

    a_stage_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bv |-> (r_state == S_ROW || r_state == S_DRAIN || r_state == S_CELL))
        else $error("cell stage active outside a comparison");

    a_rows_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_rows_left != '0))
        else $error("cell walk with no rows left");

    a_empty_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_fcount == '0) |-> (o_match_length == 8'd0))
        else $error("match reported against an empty field");

endmodule

>>> bench/cyclic_longest_common_substring_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_longest_common_substring_unit_tb - self-checking bench for the run finder
// Loads field and pattern words through the start/busy handshake with random
// gaps. A behavioural run-length table predicts each comparison, and every
// strobed result is checked in order against it. Covers an empty field, last
// on field symbols, no match, cyclic wrap, ties, full words and dropped symbols.
// ----------------------------------------------------------------------------
module cyclic_longest_common_substring_unit_tb;

    localparam int MAX_WORD     = 64;
    localparam int ROW_CELLS    = 2 * MAX_WORD + 1;
    localparam int RANDOM_ITEMS = 1030;
    localparam int TAIL_ITEMS   = 120;
    localparam int IDLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    localparam logic       MODE_FIELD   = 1'b0;
    localparam logic       MODE_PATTERN = 1'b1;
    localparam logic [1:0] SYM_A        = 2'd0;
    localparam logic [1:0] SYM_B        = 2'd1;
    localparam logic [1:0] SYM_C        = 2'd2;
    localparam logic [1:0] SYM_D        = 2'd3;

    typedef struct {
        logic [7:0] match_length;
        logic [5:0] field_start;
        logic [5:0] pattern_start;
        logic [1:0] tag_out;
        logic       overflow;
    } t_run_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_mode;
    logic [1:0] i_symbol;
    logic       i_last;
    logic [1:0] i_rotation_tag;
    logic       o_valid;
    logic [7:0] o_match_length;
    logic [5:0] o_field_start;
    logic [5:0] o_pattern_start;
    logic [1:0] o_tag_out;
    logic       o_overflow;

    logic [1:0]  field_word [MAX_WORD];
    logic [1:0]  pattern_word [MAX_WORD];
    int          field_len = 0;
    int          pattern_len = 0;
    logic        drop_seen = 1'b0;
    t_run_result pending_runs [$];
    t_run_result checked_run;
    int          mismatch_count = 0;
    int          sent_items = 0;
    int          idle_cycles = 0;
    bit          no_gap = 1'b0;

    cyclic_longest_common_substring_unit #(
        .MAX_WORD(MAX_WORD)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_symbol       (i_symbol),
        .i_last         (i_last),
        .i_rotation_tag (i_rotation_tag),
        .o_valid        (o_valid),
        .o_match_length (o_match_length),
        .o_field_start  (o_field_start),
        .o_pattern_start(o_pattern_start),
        .o_tag_out      (o_tag_out),
        .o_overflow     (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_run_result predict_longest_run(input logic [1:0] tag);
        t_run_result res;
        int run_len [2][ROW_CELLS];
        int a;
        int b;
        int best;
        int fpos;
        int ppos;
        int prev;
        int cur;
        int len;
        a    = 2 * field_len;
        b    = 2 * pattern_len;
        best = 0;
        fpos = 0;
        ppos = 0;
        prev = 0;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < ROW_CELLS; c++) begin
                run_len[r][c] = 0;
            end
        end
        for (int i = a - 1; i >= 0; i--) begin
            cur = prev ^ 1;
            for (int j = b - 1; j >= 0; j--) begin
                if (field_word[i % field_len] != pattern_word[j % pattern_len]) begin
                    run_len[cur][j] = 0;
                end else begin
                    len = 1 + run_len[prev][j + 1];
                    if (len > best) begin
                        best = len;
                        fpos = i % field_len;
                        ppos = j % pattern_len;
                    end
                    run_len[cur][j] = len;
                end
            end
            prev = cur;
        end
        res.match_length  = (best > 255) ? 8'd255 : 8'(best);
        res.field_start   = 6'(fpos);
        res.pattern_start = 6'(ppos);
        res.tag_out       = tag;
        res.overflow      = drop_seen;
        return res;
    endfunction

    function automatic void absorb_symbol(input logic mode, input logic [1:0] sym,
                                          input logic last, input logic [1:0] tag);
        if (mode == MODE_FIELD) begin
            if (field_len < MAX_WORD) begin
                field_word[field_len] = sym;
                field_len++;
            end else begin
                drop_seen = 1'b1;
            end
        end else begin
            if (pattern_len < MAX_WORD) begin
                pattern_word[pattern_len] = sym;
                pattern_len++;
            end else begin
                drop_seen = 1'b1;
            end
            if (last) begin
                pending_runs.insert(pending_runs.size(), predict_longest_run(tag));
                pattern_len = 0;
            end
        end
    endfunction

    task automatic send_symbol(input logic mode, input logic [1:0] sym,
                               input logic last, input logic [1:0] tag);
        int   gap;
        logic was_busy;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_mode         <= mode;
        i_symbol       <= sym;
        i_last         <= last;
        i_rotation_tag <= tag;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
        absorb_symbol(mode, sym, last, tag);
        sent_items++;
    endtask

    task automatic send_pattern(input int len, input logic [1:0] tag);
        logic [1:0] sym;
        int         style;
        int         offset;
        int         mutate_at;
        style     = $urandom_range(0, 3);
        offset    = $urandom_range(0, MAX_WORD - 1);
        mutate_at = $urandom_range(0, 3 * len);
        for (int k = 0; k < len; k++) begin
            if (style <= 1 && field_len > 0) begin
                sym = field_word[(offset + k) % field_len];
            end else if (style == 2) begin
                sym = 2'($urandom_range(0, 1));
            end else begin
                sym = 2'($urandom_range(0, 3));
            end
            if (k == mutate_at) begin
                sym = 2'($urandom_range(0, 3));
            end
            if (k != len - 1 && field_len < MAX_WORD && $urandom_range(0, 31) == 0) begin
                send_symbol(MODE_FIELD, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            2'($urandom_range(0, 3)));
            end
            send_symbol(MODE_PATTERN, sym, k == len - 1,
                        (k == len - 1) ? tag : 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_empty_field;
        no_gap = 1'b1;
        send_symbol(MODE_PATTERN, SYM_D, 1'b1, 2'd3);
        send_symbol(MODE_PATTERN, SYM_A, 1'b0, 2'd1);
        send_symbol(MODE_PATTERN, SYM_B, 1'b0, 2'd2);
        send_symbol(MODE_PATTERN, SYM_C, 1'b0, 2'd3);
        send_symbol(MODE_PATTERN, SYM_D, 1'b1, 2'd0);
    endtask

    task automatic test_last_on_field;
        no_gap = 1'b0;
        send_symbol(MODE_FIELD, SYM_A, 1'b1, 2'd1);
        send_symbol(MODE_FIELD, SYM_A, 1'b0, 2'd2);
    endtask

    task automatic test_no_match;
        send_symbol(MODE_PATTERN, SYM_B, 1'b0, 2'd0);
        send_symbol(MODE_PATTERN, SYM_C, 1'b0, 2'd0);
        send_symbol(MODE_PATTERN, SYM_D, 1'b1, 2'd1);
        send_symbol(MODE_PATTERN, SYM_A, 1'b1, 2'd2);
    endtask

    task automatic test_cyclic_wrap;
        send_symbol(MODE_FIELD, SYM_B, 1'b0, 2'd0);
        send_symbol(MODE_FIELD, SYM_C, 1'b1, 2'd3);
        send_symbol(MODE_FIELD, SYM_D, 1'b0, 2'd0);
        send_symbol(MODE_PATTERN, SYM_D, 1'b0, 2'd0);
        send_symbol(MODE_PATTERN, SYM_A, 1'b0, 2'd0);
        send_symbol(MODE_PATTERN, SYM_A, 1'b0, 2'd0);
        send_symbol(MODE_PATTERN, SYM_B, 1'b1, 2'd3);
        send_symbol(MODE_PATTERN, SYM_C, 1'b1, 2'd2);
    endtask

    task automatic test_random_patterns(input int quota);
        int target;
        int len;
        target = sent_items + quota;
        while (sent_items < target) begin
            no_gap = ($urandom_range(0, 3) == 0);
            if (field_len < MAX_WORD && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    if (field_len < MAX_WORD) begin
                        send_symbol(MODE_FIELD, 2'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                    end
                end
            end
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_pattern(len, 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_word_full;
        no_gap = 1'b0;
        while (field_len < MAX_WORD) begin
            send_symbol(MODE_FIELD, 2'($urandom_range(0, 3)), 1'b0, 2'($urandom_range(0, 3)));
        end
        send_pattern(MAX_WORD, 2'($urandom_range(0, 3)));
        send_symbol(MODE_FIELD, SYM_D, 1'b1, 2'($urandom_range(0, 3)));
        for (int k = 0; k <= MAX_WORD + 1; k++) begin
            send_symbol(MODE_PATTERN, 2'($urandom_range(0, 3)), k == MAX_WORD + 1,
                        2'($urandom_range(0, 3)));
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_runs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result: len %0d fs %0d ps %0d tag %0d ovf %0b",
                             o_match_length, o_field_start, o_pattern_start, o_tag_out,
                             o_overflow);
                end
            end else begin
                checked_run = pending_runs.pop_front();
                if (o_match_length !== checked_run.match_length
                        || o_field_start !== checked_run.field_start
                        || o_pattern_start !== checked_run.pattern_start
                        || o_tag_out !== checked_run.tag_out
                        || o_overflow !== checked_run.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected len %0d fs %0d ps %0d tag %0d ovf %0b",
                                 checked_run.match_length, checked_run.field_start,
                                 checked_run.pattern_start, checked_run.tag_out,
                                 checked_run.overflow);
                        $display("          got      len %0d fs %0d ps %0d tag %0d ovf %0b",
                                 o_match_length, o_field_start, o_pattern_start, o_tag_out,
                                 o_overflow);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("cyclic_longest_common_substring_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_mode         <= MODE_FIELD;
        i_symbol       <= SYM_A;
        i_last         <= 1'b0;
        i_rotation_tag <= 2'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_field;
        test_last_on_field;
        test_no_match;
        test_cyclic_wrap;
        test_random_patterns(RANDOM_ITEMS);
        test_word_full;
        test_random_patterns(TAIL_ITEMS);

        start <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_runs.size() == 0) begin
            $display("cyclic_longest_common_substring_unit_tb: clean");
        end else begin
            $display("cyclic_longest_common_substring_unit_tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/clcs_pkg.sv
hw/rtl/cyclic_longest_common_substring_unit.sv
bench/cyclic_longest_common_substring_unit_tb.sv
